[sv/lrt_pkg.sv]
// Shared types, codes and fixed-point constants of the landmark region tracker.
// Used by every module of the block; depends on nothing.
package lrt_pkg;

  localparam int COORD_BITS_DEF = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CROP_W  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CROP_H  = 2'd3;

  localparam logic [12:0] FRAME_W_RST = 13'd640;
  localparam logic [12:0] FRAME_H_RST = 13'd480;
  localparam logic [12:0] FRAME_TOP   = 13'd4096;
  localparam logic [10:0] CROP_RST    = 11'd224;
  localparam logic [12:0] CROP_TOP    = 13'd1024;

  localparam int KW = 24;
  localparam logic signed [KW-1:0] ONE_Q    = 24'sd65536;
  localparam logic signed [KW-1:0] HALF_Q   = 24'sd32768;
  localparam logic signed [KW-1:0] K_SCALE  = 24'sd117965;
  localparam logic signed [KW-1:0] K_SHIFT  = -24'sd3277;
  localparam logic signed [KW-1:0] K_ALPHA  = 24'sd22938;
  localparam logic signed [KW-1:0] K_SHRINK = 24'sd60293;
  localparam logic signed [KW-1:0] K_GROW   = 24'sd78643;
  localparam logic signed [KW-1:0] K_MINPX  = 24'sd2097152;

  localparam logic [1:0] KIND_POINT  = 2'd0;
  localparam logic [1:0] KIND_BOX    = 2'd1;
  localparam logic [1:0] KIND_CORNER = 2'd2;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  localparam logic MD_MUL = 1'b0;
  localparam logic MD_DIV = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [30:0]        size_w;
    logic [30:0]        size_h;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] depth_z;
    logic [30:0]        box_width;
    logic [30:0]        box_height;
    logic [1:0]         corner_index;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [12:0] frame_w;
    logic [12:0] frame_h;
    logic [10:0] crop_w;
    logic [10:0] crop_h;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic op;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_rsp_t;

endpackage

[sv/lrt_muldiv.sv]
// Shared iterative unit: saturating Q16.16 multiply (one bit a cycle) and
// restoring divide by a 13-bit count (one quotient bit a cycle). Uses lrt_pkg.
module lrt_muldiv #(
  parameter int W   = lrt_pkg::COORD_BITS_DEF,
  parameter int OPW = W + 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lrt_pkg::md_req_t      req,
  input  logic signed [OPW-1:0] op_a,
  input  logic signed [OPW-1:0] op_b,
  output lrt_pkg::md_rsp_t      rsp,
  output logic signed [W-1:0]   result
);

  localparam int PW   = 2 * OPW;
  localparam int DW   = W + 16;
  localparam int NMAX = (OPW > DW) ? OPW : DW;
  localparam int CW   = $clog2(NMAX + 1);
  localparam logic [PW-1:0] LIM_P = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [PW-1:0] LIM_N = LIM_P + 1'b1;

  logic              run_r, done_r, op_r, neg_r;
  logic [CW-1:0]     cnt_r;
  logic [PW-1:0]     acc_r;
  logic [OPW-1:0]    mcand_r;
  logic [DW-1:0]     dq_r;
  logic [12:0]       rem_r, den_r;
  logic signed [W-1:0] res_r;

  logic [OPW:0]      sum;
  logic [PW-1:0]     acc_nxt;
  logic [13:0]       trial, trial_sub;
  logic              ge;
  logic [12:0]       rem_nxt;
  logic [DW-1:0]     dq_nxt;
  logic [W-1:0]      num_mag;
  logic signed [W-1:0] num;

  function automatic logic [OPW-1:0] mag(input logic signed [OPW-1:0] v);
    mag = v[OPW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic signed [W-1:0] from_mag(input logic neg, input logic [PW-1:0] m);
    logic [PW-1:0] mm;
    if (neg) begin
      mm = (m > LIM_N) ? LIM_N : m;
      from_mag = ~mm[W-1:0] + 1'b1;
    end else begin
      mm = (m > LIM_P) ? LIM_P : m;
      from_mag = mm[W-1:0];
    end
  endfunction

  always_comb begin
    num       = op_a[W-1:0];
    num_mag   = num[W-1] ? (~num + 1'b1) : num;
    sum       = {1'b0, acc_r[PW-1:OPW]} + {1'b0, mcand_r};
    acc_nxt   = acc_r[0] ? {sum, acc_r[OPW-1:1]} : {1'b0, acc_r[PW-1:1]};
    trial     = {rem_r, dq_r[DW-1]};
    ge        = trial >= {1'b0, den_r};
    trial_sub = trial - {1'b0, den_r};
    rem_nxt   = ge ? trial_sub[12:0] : trial[12:0];
    dq_nxt    = {dq_r[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !run_r) begin
        run_r   <= 1'b1;
        op_r    <= req.op;
        cnt_r   <= (req.op == lrt_pkg::MD_DIV) ? CW'(DW) : CW'(OPW);
        neg_r   <= (req.op == lrt_pkg::MD_DIV) ? num[W-1] : (op_a[OPW-1] ^ op_b[OPW-1]);
        acc_r   <= {{OPW{1'b0}}, mag(op_b)};
        mcand_r <= mag(op_a);
        dq_r    <= {num_mag, 16'b0};
        rem_r   <= '0;
        den_r   <= op_b[12:0];
      end else if (run_r) begin
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - 1'b1;
          if (op_r == lrt_pkg::MD_DIV) begin
            rem_r <= rem_nxt;
            dq_r  <= dq_nxt;
          end else begin
            acc_r <= acc_nxt;
          end
        end else begin
          res_r  <= (op_r == lrt_pkg::MD_DIV) ? from_mag(neg_r, PW'(dq_r))
                                              : from_mag(neg_r, acc_r >> 16);
          done_r <= 1'b1;
          run_r  <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy = run_r;
  assign rsp.done = done_r;
  assign result   = res_r;

endmodule

[sv/lrt_seq.sv]
// Sequencer: holds the region and bounds, steps through the point mapping and
// the region update on the shared unit, and emits results. Uses lrt_pkg.
module lrt_seq #(
  parameter int W   = lrt_pkg::COORD_BITS_DEF,
  parameter int OPW = W + 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  lrt_pkg::in_item_t     in_item,
  input  lrt_pkg::cfg_t         cfg,
  output lrt_pkg::md_req_t      md_req,
  output logic signed [OPW-1:0] op_a,
  output logic signed [OPW-1:0] op_b,
  input  lrt_pkg::md_rsp_t      md_rsp,
  input  logic signed [W-1:0]   md_res,
  output logic                  out_strobe,
  output lrt_pkg::out_item_t    out_item
);

  localparam int SW = (W + 2 > 34) ? W + 2 : 34;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_P_DX  = 5'd1;
  localparam logic [4:0] ST_P_MX  = 5'd2;
  localparam logic [4:0] ST_P_DY  = 5'd3;
  localparam logic [4:0] ST_P_MY  = 5'd4;
  localparam logic [4:0] ST_P_OUT = 5'd5;
  localparam logic [4:0] ST_L_BW  = 5'd6;
  localparam logic [4:0] ST_L_BH  = 5'd7;
  localparam logic [4:0] ST_L_SZ  = 5'd8;
  localparam logic [4:0] ST_L_PV  = 5'd9;
  localparam logic [4:0] ST_L_LO  = 5'd10;
  localparam logic [4:0] ST_L_HI  = 5'd11;
  localparam logic [4:0] ST_L_SH  = 5'd12;
  localparam logic [4:0] ST_L_DS  = 5'd13;
  localparam logic [4:0] ST_L_TW  = 5'd14;
  localparam logic [4:0] ST_L_TH  = 5'd15;
  localparam logic [4:0] ST_L_AX  = 5'd16;
  localparam logic [4:0] ST_L_AY  = 5'd17;
  localparam logic [4:0] ST_L_AW  = 5'd18;
  localparam logic [4:0] ST_L_AH  = 5'd19;
  localparam logic [4:0] ST_O_BOX = 5'd20;
  localparam logic [4:0] ST_O_C0  = 5'd21;
  localparam logic [4:0] ST_O_C1  = 5'd22;
  localparam logic [4:0] ST_O_C2  = 5'd23;
  localparam logic [4:0] ST_O_C3  = 5'd24;

  localparam logic signed [SW-1:0] S_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] S_LO = ~S_HI;
  localparam logic signed [SW-1:0] O_HI = {{(SW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0] O_LO = ~O_HI;

  localparam logic signed [W-1:0] R_ONE  = W'(lrt_pkg::ONE_Q);
  localparam logic signed [W-1:0] R_HALF = W'(lrt_pkg::HALF_Q);
  localparam logic signed [W-1:0] R_MPX  = W'(lrt_pkg::K_MINPX);

  function automatic logic signed [SW-1:0] xw(input logic signed [W-1:0] v);
    xw = SW'(v);
  endfunction

  function automatic logic signed [OPW-1:0] xo(input logic signed [W-1:0] v);
    xo = OPW'(v);
  endfunction

  function automatic logic signed [OPW-1:0] xk(input logic signed [lrt_pkg::KW-1:0] v);
    xk = OPW'(v);
  endfunction

  function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
    if (v > S_HI) sat = S_HI[W-1:0];
    else if (v < S_LO) sat = S_LO[W-1:0];
    else sat = v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] half(input logic signed [W-1:0] v);
    half = v >>> 1;
  endfunction

  function automatic logic signed [W-1:0] half_sum(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
    logic signed [SW-1:0] s;
    s = (xw(a) + xw(b)) >>> 1;
    half_sum = sat(s);
  endfunction

  function automatic logic [31:0] out32(input logic signed [W-1:0] v);
    logic signed [SW-1:0] t;
    t = xw(v);
    if (t > O_HI) t = O_HI;
    else if (t < O_LO) t = O_LO;
    out32 = t[31:0];
  endfunction

  function automatic logic [30:0] out31(input logic signed [W-1:0] v);
    logic signed [SW-1:0] t;
    t = xw(v);
    if (t < 0) t = '0;
    else if (t > O_HI) t = O_HI;
    out31 = t[30:0];
  endfunction

  logic [4:0]          st_r;
  logic                issued_r;
  logic signed [W-1:0] cx_r, cy_r;
  logic [31:0]         z_r;
  logic                last_r;
  logic signed [W-1:0] rcx_r, rcy_r, rw_r, rh_r;
  logic signed [W-1:0] bminx_r, bminy_r, bmaxx_r, bmaxy_r;
  logic signed [W-1:0] px_r, py_r, t0_r, t1_r, t2_r, size_r;
  logic                out_strobe_r;
  lrt_pkg::out_item_t  out_r;

  logic                is_op, is_div;
  logic signed [W-1:0] in_cx, in_cy, in_w, in_h;
  logic signed [W-1:0] px_new, py_new, ty_new, tx, dx, dy, dw, dh;
  logic signed [W-1:0] size_lo, cl, cr, ct, cb;

  always_comb begin
    in_cx  = sat(SW'(in_item.coord_x));
    in_cy  = sat(SW'(in_item.coord_y));
    in_w   = sat($signed({{(SW-31){1'b0}}, in_item.size_w}));
    in_h   = sat($signed({{(SW-31){1'b0}}, in_item.size_h}));
    px_new = sat(xw(sat(xw(rcx_r) - xw(half(rw_r)))) + xw(md_res));
    py_new = sat(xw(sat(xw(rcy_r) - xw(half(rh_r)))) + xw(md_res));
    ty_new = sat(xw(half_sum(bminy_r, bmaxy_r)) + xw(md_res));
    tx     = half_sum(bminx_r, bmaxx_r);
    dx     = sat(xw(tx) - xw(rcx_r));
    dy     = sat(xw(t0_r) - xw(rcy_r));
    dw     = sat(xw(t1_r) - xw(rw_r));
    dh     = sat(xw(t2_r) - xw(rh_r));
    size_lo = (size_r < R_MPX) ? R_MPX : size_r;
    cl     = sat(xw(rcx_r) - xw(half(rw_r)));
    cr     = sat(xw(rcx_r) + xw(half(rw_r)));
    ct     = sat(xw(rcy_r) - xw(half(rh_r)));
    cb     = sat(xw(rcy_r) + xw(half(rh_r)));
  end

  always_comb begin
    is_op  = 1'b1;
    is_div = 1'b0;
    op_a   = '0;
    op_b   = '0;
    case (st_r)
      ST_P_DX: begin
        is_div = 1'b1;
        op_a   = xo(cx_r);
        op_b   = $signed(OPW'(cfg.crop_w));
      end
      ST_P_MX: begin
        op_a = xo(t0_r);
        op_b = xo(rw_r);
      end
      ST_P_DY: begin
        is_div = 1'b1;
        op_a   = xo(cy_r);
        op_b   = $signed(OPW'(cfg.crop_h));
      end
      ST_P_MY: begin
        op_a = xo(t0_r);
        op_b = xo(rh_r);
      end
      ST_L_BW: begin
        op_a = xo(bmaxx_r) - xo(bminx_r);
        op_b = $signed(OPW'({cfg.frame_w, 16'b0}));
      end
      ST_L_BH: begin
        op_a = xo(bmaxy_r) - xo(bminy_r);
        op_b = $signed(OPW'({cfg.frame_h, 16'b0}));
      end
      ST_L_SZ: begin
        op_a = (t0_r > t1_r) ? xo(t0_r) : xo(t1_r);
        op_b = xk(lrt_pkg::K_SCALE);
      end
      ST_L_PV: begin
        op_a = xo(rw_r);
        op_b = $signed(OPW'({cfg.frame_w, 16'b0}));
      end
      ST_L_LO: begin
        op_a = xo(t0_r);
        op_b = xk(lrt_pkg::K_SHRINK);
      end
      ST_L_HI: begin
        op_a = xo(t0_r);
        op_b = xk(lrt_pkg::K_GROW);
      end
      ST_L_SH: begin
        op_a = xo(size_r);
        op_b = xk(lrt_pkg::K_SHIFT);
      end
      ST_L_DS: begin
        is_div = 1'b1;
        op_a   = xo(t0_r);
        op_b   = $signed(OPW'(cfg.frame_h));
      end
      ST_L_TW: begin
        is_div = 1'b1;
        op_a   = xo(size_r);
        op_b   = $signed(OPW'(cfg.frame_w));
      end
      ST_L_TH: begin
        is_div = 1'b1;
        op_a   = xo(size_r);
        op_b   = $signed(OPW'(cfg.frame_h));
      end
      ST_L_AX: begin
        op_a = xk(lrt_pkg::K_ALPHA);
        op_b = xo(dx);
      end
      ST_L_AY: begin
        op_a = xk(lrt_pkg::K_ALPHA);
        op_b = xo(dy);
      end
      ST_L_AW: begin
        op_a = xk(lrt_pkg::K_ALPHA);
        op_b = xo(dw);
      end
      ST_L_AH: begin
        op_a = xk(lrt_pkg::K_ALPHA);
        op_b = xo(dh);
      end
      default: begin
        is_op = 1'b0;
      end
    endcase
  end

  assign md_req.start = is_op && !issued_r && !md_rsp.busy;
  assign md_req.op    = is_div ? lrt_pkg::MD_DIV : lrt_pkg::MD_MUL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      issued_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      rcx_r        <= R_HALF;
      rcy_r        <= R_HALF;
      rw_r         <= R_ONE;
      rh_r         <= R_ONE;
      bminx_r      <= R_ONE;
      bminy_r      <= R_ONE;
      bmaxx_r      <= '0;
      bmaxy_r      <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      if (md_req.start) issued_r <= 1'b1;
      if (md_rsp.done) issued_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (start) begin
            if (in_item.mode) begin
              rcx_r   <= in_cx;
              rcy_r   <= in_cy;
              rw_r    <= in_w;
              rh_r    <= in_h;
              bminx_r <= R_ONE;
              bminy_r <= R_ONE;
              bmaxx_r <= '0;
              bmaxy_r <= '0;
            end else begin
              cx_r   <= in_cx;
              cy_r   <= in_cy;
              z_r    <= in_item.coord_z;
              last_r <= in_item.last_point;
              st_r   <= ST_P_DX;
            end
          end
        end
        ST_P_OUT: begin
          if (px_r < bminx_r) bminx_r <= px_r;
          if (px_r > bmaxx_r) bmaxx_r <= px_r;
          if (py_r < bminy_r) bminy_r <= py_r;
          if (py_r > bmaxy_r) bmaxy_r <= py_r;
          out_strobe_r       <= 1'b1;
          out_r.kind         <= lrt_pkg::KIND_POINT;
          out_r.pos_x        <= out32(px_r);
          out_r.pos_y        <= out32(py_r);
          out_r.depth_z      <= z_r;
          out_r.box_width    <= '0;
          out_r.box_height   <= '0;
          out_r.corner_index <= lrt_pkg::CORNER_TL;
          out_r.last_of_run  <= !last_r;
          st_r <= last_r ? ST_L_BW : ST_IDLE;
        end
        ST_O_BOX: begin
          out_strobe_r       <= 1'b1;
          out_r.kind         <= lrt_pkg::KIND_BOX;
          out_r.pos_x        <= out32(rcx_r);
          out_r.pos_y        <= out32(rcy_r);
          out_r.depth_z      <= '0;
          out_r.box_width    <= out31(rw_r);
          out_r.box_height   <= out31(rh_r);
          out_r.corner_index <= lrt_pkg::CORNER_TL;
          out_r.last_of_run  <= 1'b0;
          st_r <= ST_O_C0;
        end
        ST_O_C0, ST_O_C1, ST_O_C2, ST_O_C3: begin
          out_strobe_r     <= 1'b1;
          out_r.kind       <= lrt_pkg::KIND_CORNER;
          out_r.depth_z    <= '0;
          out_r.box_width  <= '0;
          out_r.box_height <= '0;
          out_r.last_of_run <= (st_r == ST_O_C3);
          out_r.pos_x <= out32((st_r == ST_O_C0 || st_r == ST_O_C3) ? cl : cr);
          out_r.pos_y <= out32((st_r == ST_O_C0 || st_r == ST_O_C1) ? ct : cb);
          if (st_r == ST_O_C0) begin
            out_r.corner_index <= lrt_pkg::CORNER_TL;
            st_r <= ST_O_C1;
          end else if (st_r == ST_O_C1) begin
            out_r.corner_index <= lrt_pkg::CORNER_TR;
            st_r <= ST_O_C2;
          end else if (st_r == ST_O_C2) begin
            out_r.corner_index <= lrt_pkg::CORNER_BR;
            st_r <= ST_O_C3;
          end else begin
            out_r.corner_index <= lrt_pkg::CORNER_BL;
            st_r <= ST_IDLE;
          end
        end
        default: begin
          if (md_rsp.done) begin
            case (st_r)
              ST_P_DX: begin t0_r <= md_res; st_r <= ST_P_MX; end
              ST_P_MX: begin px_r <= px_new; st_r <= ST_P_DY; end
              ST_P_DY: begin t0_r <= md_res; st_r <= ST_P_MY; end
              ST_P_MY: begin py_r <= py_new; st_r <= ST_P_OUT; end
              ST_L_BW: begin t0_r <= md_res; st_r <= ST_L_BH; end
              ST_L_BH: begin t1_r <= md_res; st_r <= ST_L_SZ; end
              ST_L_SZ: begin size_r <= md_res; st_r <= ST_L_PV; end
              ST_L_PV: begin t0_r <= md_res; st_r <= ST_L_LO; end
              ST_L_LO: begin
                if (size_r < md_res) size_r <= md_res;
                st_r <= ST_L_HI;
              end
              ST_L_HI: begin
                size_r <= (size_lo > md_res) ? md_res : size_lo;
                st_r   <= ST_L_SH;
              end
              ST_L_SH: begin t0_r <= md_res; st_r <= ST_L_DS; end
              ST_L_DS: begin t0_r <= ty_new; st_r <= ST_L_TW; end
              ST_L_TW: begin t1_r <= md_res; st_r <= ST_L_TH; end
              ST_L_TH: begin t2_r <= md_res; st_r <= ST_L_AX; end
              ST_L_AX: begin rcx_r <= sat(xw(rcx_r) + xw(md_res)); st_r <= ST_L_AY; end
              ST_L_AY: begin rcy_r <= sat(xw(rcy_r) + xw(md_res)); st_r <= ST_L_AW; end
              ST_L_AW: begin rw_r <= sat(xw(rw_r) + xw(md_res)); st_r <= ST_L_AH; end
              ST_L_AH: begin
                rh_r    <= sat(xw(rh_r) + xw(md_res));
                bminx_r <= R_ONE;
                bminy_r <= R_ONE;
                bmaxx_r <= '0;
                bmaxy_r <= '0;
                st_r    <= ST_O_BOX;
              end
              default: st_r <= ST_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  assign busy       = (st_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

[sv/landmark_roi_tracker_top.sv]
// Top level of the landmark region tracker: configuration registers, the
// sequencer and the shared multiply/divide unit. Uses lrt_pkg.
// OPW = max(COORD_BITS+1, 29)+1 is the operand width of the shared unit.
// A point runs two divides and two multiplies, then its output; a load uses neither.
// The last point adds eleven multiplies, three divides and five results.
// Reset loads the default region and frame sizes; results cannot be stalled.
module landmark_roi_tracker_top #(
  parameter int COORD_BITS = lrt_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  lrt_pkg::in_item_t                   in_item,
  output logic                                out_strobe,
  output lrt_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [lrt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lrt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int MAGW = (COORD_BITS + 1 > 29) ? COORD_BITS + 1 : 29;
  localparam int OPW  = MAGW + 1;

  lrt_pkg::cfg_t           cfg_r;
  lrt_pkg::md_req_t        md_req;
  lrt_pkg::md_rsp_t        md_rsp;
  logic signed [OPW-1:0]   op_a, op_b;
  logic signed [COORD_BITS-1:0] md_res;
  logic [12:0]             frame_v, crop_v;

  always_comb begin
    frame_v = (cfg_wdata == '0) ? 13'd1 :
              (cfg_wdata > lrt_pkg::FRAME_TOP) ? lrt_pkg::FRAME_TOP : cfg_wdata;
    crop_v  = (cfg_wdata == '0) ? 13'd1 :
              (cfg_wdata > lrt_pkg::CROP_TOP) ? lrt_pkg::CROP_TOP : cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_w <= lrt_pkg::FRAME_W_RST;
      cfg_r.frame_h <= lrt_pkg::FRAME_H_RST;
      cfg_r.crop_w  <= lrt_pkg::CROP_RST;
      cfg_r.crop_h  <= lrt_pkg::CROP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lrt_pkg::CFG_FRAME_W: cfg_r.frame_w <= frame_v;
        lrt_pkg::CFG_FRAME_H: cfg_r.frame_h <= frame_v;
        lrt_pkg::CFG_CROP_W:  cfg_r.crop_w  <= crop_v[10:0];
        lrt_pkg::CFG_CROP_H:  cfg_r.crop_h  <= crop_v[10:0];
        default: ;
      endcase
    end
  end

  lrt_seq #(.W(COORD_BITS), .OPW(OPW)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .cfg        (cfg_r),
    .md_req     (md_req),
    .op_a       (op_a),
    .op_b       (op_b),
    .md_rsp     (md_rsp),
    .md_res     (md_res),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  lrt_muldiv #(.W(COORD_BITS), .OPW(OPW)) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .op_a   (op_a),
    .op_b   (op_b),
    .rsp    (md_rsp),
    .result (md_res)
  );

endmodule

[sv/lrt_chk.sv]
// Port-level checker for the landmark region tracker and its bind to the top.
// Uses lrt_pkg codes.
module lrt_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input lrt_pkg::in_item_t  in_item,
  input logic               out_strobe,
  input lrt_pkg::out_item_t out_item
);

  // A point request keeps the block busy in the next cycle.
  a_point_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_item.mode |=> busy)
    else $error("point request did not make the block busy");

  // A load request completes without leaving the block busy.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.mode |=> !busy)
    else $error("load request left the block busy");

  // The box is followed at once by the top-left corner.
  a_box_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.kind == lrt_pkg::KIND_BOX |=>
      out_strobe && out_item.kind == lrt_pkg::KIND_CORNER &&
      out_item.corner_index == lrt_pkg::CORNER_TL)
    else $error("box not followed by first corner");

  // The bottom-left corner closes the run.
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.kind == lrt_pkg::KIND_CORNER &&
    out_item.corner_index == lrt_pkg::CORNER_BL |-> out_item.last_of_run)
    else $error("final corner not marked last");

  // A point that ends its run leaves the block ready.
  a_point_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.kind == lrt_pkg::KIND_POINT && out_item.last_of_run |-> !busy)
    else $error("block still busy after a single point result");

endmodule

bind landmark_roi_tracker_top lrt_chk u_lrt_chk (.*);
